@@ rtl/core/ssab_pkg.sv @@
// ----------------------------------------------------------------------------
// ssab_pkg: shared definitions of the scaled sprite alpha blitter
// Register map, fixed field widths, queue word layout and default sizes.
// ----------------------------------------------------------------------------
package ssab_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned TexWords  = 4096;
  localparam int unsigned CoordBits = 12;

  // Fixed widths of the word fields.
  localparam int unsigned PixelW    = 12;
  localparam int unsigned TexAddrW  = 12;
  localparam int unsigned ColorW    = 32;
  localparam int unsigned AddrMaxW  = 16;

  // Queue and output buffer depths, powers of two.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned OutDepth   = 8;

  // APB address width: eight registers at 4-byte spacing.
  localparam int unsigned ApbAddrW = 5;

  // Request codes.
  localparam logic ReqWrite = 1'b0;
  localparam logic ReqBlend = 1'b1;

  localparam logic [7:0] AlphaOpaque = 8'hFF;
  localparam logic [7:0] ByteMax     = 8'd255;

  typedef enum logic [2:0] {
    RegStepX     = 3'd0,
    RegStepY     = 3'd1,
    RegOriginX   = 3'd2,
    RegOriginY   = 3'd3,
    RegSrcOrigin = 3'd4,
    RegSrcSize   = 3'd5,
    RegTexWidth  = 3'd6,
    RegTint      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0]        step_x;
    logic [23:0]        step_y;
    logic signed [20:0] origin_x;
    logic signed [20:0] origin_y;
    logic [23:0]        src_origin;
    logic [25:0]        src_size;
    logic [12:0]        tex_width;
    logic [31:0]        tint_argb;
  } cfg_t;

  // One classified word handed from the front end to the back end.
  typedef struct packed {
    logic                is_write;
    logic                skip;
    logic [AddrMaxW-1:0] addr;
    logic [ColorW-1:0]   data;
  } queue_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

@@ rtl/core/ssab_in_if.sv @@
// ----------------------------------------------------------------------------
// ssab_in_if: request channel of the blitter
// Valid/ready channel carrying texel writes and blend requests.
// ----------------------------------------------------------------------------
interface ssab_in_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [ssab_pkg::TexAddrW-1:0]     tex_addr;
  logic [ssab_pkg::ColorW-1:0]       tex_data;
  logic [ssab_pkg::PixelW-1:0]       pixel_x;
  logic [ssab_pkg::PixelW-1:0]       pixel_y;
  logic [ssab_pkg::ColorW-1:0]       dest_color;

  modport source (
    output valid, req_type, tex_addr, tex_data, pixel_x, pixel_y, dest_color,
    input  ready
  );
  modport sink (
    input  valid, req_type, tex_addr, tex_data, pixel_x, pixel_y, dest_color,
    output ready
  );
endinterface

@@ rtl/core/ssab_out_if.sv @@
// ----------------------------------------------------------------------------
// ssab_out_if: result channel of the blitter
// Valid/ready channel carrying the new destination pixel.
// ----------------------------------------------------------------------------
interface ssab_out_if;
  logic                        valid;
  logic                        ready;
  logic [ssab_pkg::ColorW-1:0] out_color;
  logic                        written;

  modport source (output valid, out_color, written, input ready);
  modport sink (input valid, out_color, written, output ready);
endinterface

@@ rtl/core/ssab_ram.sv @@
// ----------------------------------------------------------------------------
// ssab_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module ssab_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/ssab_cfg.sv @@
// ----------------------------------------------------------------------------
// ssab_cfg: configuration registers
// APB register file holding scale, origin, source rectangle and tint.
// ----------------------------------------------------------------------------
module ssab_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssab_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output ssab_pkg::cfg_t                cfg_o
);

  ssab_pkg::cfg_t     cfg_q;
  ssab_pkg::cfg_idx_e idx;
  logic               wr_en;

  assign idx    = ssab_pkg::cfg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_x     <= 24'h010000;
      cfg_q.step_y     <= 24'h010000;
      cfg_q.origin_x   <= '0;
      cfg_q.origin_y   <= '0;
      cfg_q.src_origin <= '0;
      cfg_q.src_size   <= '0;
      cfg_q.tex_width  <= 13'd1;
      cfg_q.tint_argb  <= 32'hFFFF_FFFF;
    end else if (wr_en) begin
      unique case (idx)
        ssab_pkg::RegStepX:     cfg_q.step_x     <= pwdata[23:0];
        ssab_pkg::RegStepY:     cfg_q.step_y     <= pwdata[23:0];
        ssab_pkg::RegOriginX:   cfg_q.origin_x   <= $signed(pwdata[20:0]);
        ssab_pkg::RegOriginY:   cfg_q.origin_y   <= $signed(pwdata[20:0]);
        ssab_pkg::RegSrcOrigin: cfg_q.src_origin <= pwdata[23:0];
        ssab_pkg::RegSrcSize:   cfg_q.src_size   <= pwdata[25:0];
        ssab_pkg::RegTexWidth:  cfg_q.tex_width  <= pwdata[12:0];
        ssab_pkg::RegTint:      cfg_q.tint_argb  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      ssab_pkg::RegStepX:     prdata = 32'(cfg_q.step_x);
      ssab_pkg::RegStepY:     prdata = 32'(cfg_q.step_y);
      ssab_pkg::RegOriginX:   prdata = 32'({11'd0, cfg_q.origin_x});
      ssab_pkg::RegOriginY:   prdata = 32'({11'd0, cfg_q.origin_y});
      ssab_pkg::RegSrcOrigin: prdata = 32'(cfg_q.src_origin);
      ssab_pkg::RegSrcSize:   prdata = 32'(cfg_q.src_size);
      ssab_pkg::RegTexWidth:  prdata = 32'(cfg_q.tex_width);
      ssab_pkg::RegTint:      prdata = cfg_q.tint_argb;
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/ssab_front.sv @@
// ----------------------------------------------------------------------------
// ssab_front: request front end
// Accepts words, maps a pixel to its texel address and flags skips.
// ----------------------------------------------------------------------------
module ssab_front #(
  parameter int unsigned TEX_WORDS  = ssab_pkg::TexWords,
  parameter int unsigned COORD_BITS = ssab_pkg::CoordBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  ssab_in_if.sink                in_i,
  input  ssab_pkg::cfg_t         cfg_i,
  input  ssab_pkg::queue_status_t q_stat_i,
  output logic                   q_push_o,
  output ssab_pkg::queue_entry_t q_entry_o
);

  localparam int unsigned AW    = $clog2(TEX_WORDS);
  localparam int unsigned XW    = (AW > ssab_pkg::TexAddrW) ? AW : ssab_pkg::TexAddrW;
  localparam int unsigned DiffW = 22;
  localparam int unsigned ProdW = DiffW + 25;
  localparam int unsigned UW    = ProdW - 1 - 24;
  localparam int unsigned SoW   = 2 * COORD_BITS;
  localparam int unsigned SsW   = 2 * (COORD_BITS + 1);
  localparam int unsigned RcW   = COORD_BITS + 2;
  localparam int unsigned MulW  = RcW + 13;

  logic en;

  // Stage 1: offset from the destination origin, Q.8.
  logic                    s1_v_q, s1_wr_q, s1_skip_q;
  logic [AW-1:0]           s1_waddr_q;
  logic [31:0]             s1_data_q;
  logic signed [DiffW-1:0] s1_dx_q, s1_dy_q;
  // Stage 2: scaled offset, Q.24.
  logic                    s2_v_q, s2_wr_q, s2_skip_q;
  logic [AW-1:0]           s2_waddr_q;
  logic [31:0]             s2_data_q;
  logic signed [ProdW-1:0] s2_px_q, s2_py_q;
  // Stage 3: clipped source row and column.
  logic                    s3_v_q, s3_wr_q, s3_skip_q;
  logic [AW-1:0]           s3_waddr_q;
  logic [31:0]             s3_data_q;
  logic [RcW-1:0]          s3_row_q, s3_col_q;
  // Stage 4: queue word.
  logic                    s4_v_q;
  ssab_pkg::queue_entry_t  s4_q;

  logic signed [DiffW-1:0] pos_x, pos_y, dx_d, dy_d;
  logic signed [20:0]      org_x, org_y;
  logic [XW-1:0]           waddr_ext;
  logic [SoW+23:0]         so_ext;
  logic [SsW+25:0]         ss_ext;
  logic [COORD_BITS-1:0]   sx, sy;
  logic [COORD_BITS:0]     sw, sh;
  logic [UW-1:0]           ux, uy;
  logic                    in_x, in_y;
  logic [MulW:0]           addr_sum;

  assign en         = !s4_v_q || !q_stat_i.full;
  assign in_i.ready = en;

  assign org_x     = cfg_i.origin_x;
  assign org_y     = cfg_i.origin_y;
  assign pos_x     = $signed({2'b00, in_i.pixel_x, 8'h00});
  assign pos_y     = $signed({2'b00, in_i.pixel_y, 8'h00});
  assign dx_d      = pos_x - DiffW'(org_x);
  assign dy_d      = pos_y - DiffW'(org_y);
  assign waddr_ext = XW'(in_i.tex_addr);

  // Source rectangle fields; the register is split at the coordinate width.
  assign so_ext = (SoW + 24)'(cfg_i.src_origin);
  assign ss_ext = (SsW + 26)'(cfg_i.src_size);
  assign sx     = so_ext[COORD_BITS-1:0];
  assign sy     = so_ext[SoW-1:COORD_BITS];
  assign sw     = ss_ext[COORD_BITS:0];
  assign sh     = ss_ext[SsW-1:COORD_BITS+1];

  // A negative product skips; otherwise the integer part must lie in the rectangle.
  assign ux   = s2_px_q[ProdW-2:24];
  assign uy   = s2_py_q[ProdW-2:24];
  assign in_x = !s2_px_q[ProdW-1] && (ux < UW'(sw));
  assign in_y = !s2_py_q[ProdW-1] && (uy < UW'(sh));

  assign addr_sum = (MulW + 1)'(s3_row_q * cfg_i.tex_width) + (MulW + 1)'(s3_col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_i.valid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_wr_q    <= (in_i.req_type == ssab_pkg::ReqWrite);
      s1_skip_q  <= (cfg_i.tint_argb[31:24] == 8'd0);
      s1_waddr_q <= waddr_ext[AW-1:0];
      s1_data_q  <= (in_i.req_type == ssab_pkg::ReqWrite) ? in_i.tex_data : in_i.dest_color;
      s1_dx_q    <= dx_d;
      s1_dy_q    <= dy_d;

      s2_wr_q    <= s1_wr_q;
      s2_skip_q  <= s1_skip_q;
      s2_waddr_q <= s1_waddr_q;
      s2_data_q  <= s1_data_q;
      s2_px_q    <= s1_dx_q * $signed({1'b0, cfg_i.step_x});
      s2_py_q    <= s1_dy_q * $signed({1'b0, cfg_i.step_y});

      s3_wr_q    <= s2_wr_q;
      s3_skip_q  <= s2_skip_q || !in_x || !in_y;
      s3_waddr_q <= s2_waddr_q;
      s3_data_q  <= s2_data_q;
      s3_col_q   <= RcW'(sx) + RcW'(ux[COORD_BITS:0]);
      s3_row_q   <= RcW'(sy) + RcW'(uy[COORD_BITS:0]);

      s4_q.is_write <= s3_wr_q;
      s4_q.skip     <= s3_skip_q;
      s4_q.data     <= s3_data_q;
      s4_q.addr     <= s3_wr_q ? ssab_pkg::AddrMaxW'(s3_waddr_q)
                               : ssab_pkg::AddrMaxW'(addr_sum[AW-1:0]);
    end
  end

  assign q_push_o  = s4_v_q && !q_stat_i.full;
  assign q_entry_o = s4_q;

endmodule

@@ rtl/core/ssab_queue.sv @@
// ----------------------------------------------------------------------------
// ssab_queue: front-to-back queue
// Short FIFO of classified words between the front end and the back end.
// ----------------------------------------------------------------------------
module ssab_queue #(
  parameter int unsigned Depth = ssab_pkg::QueueDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  ssab_pkg::queue_entry_t  entry_i,
  input  logic                    pop_i,
  output ssab_pkg::queue_entry_t  head_o,
  output ssab_pkg::queue_status_t stat_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  ssab_pkg::queue_entry_t mem_q [Depth];
  logic [PtrW-1:0]        wptr_q, rptr_q;
  logic [CntW-1:0]        cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= entry_i;
  end

  assign head_o       = mem_q[rptr_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == CntW'(Depth));

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && stat_o.full))
    else $error("queue written while full");

endmodule

@@ rtl/core/ssab_back.sv @@
// ----------------------------------------------------------------------------
// ssab_back: texel store and blend back end
// Executes texel writes, fetches texels, blends and buffers the results.
// ----------------------------------------------------------------------------
module ssab_back #(
  parameter int unsigned TEX_WORDS = ssab_pkg::TexWords
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ssab_pkg::queue_entry_t  q_head_i,
  input  ssab_pkg::queue_status_t q_stat_i,
  output logic                    q_pop_o,
  input  logic [31:0]             tint_i,
  ssab_out_if.source              out_o
);

  localparam int unsigned AW   = $clog2(TEX_WORDS);
  localparam int unsigned PtrW = $clog2(ssab_pkg::OutDepth);
  localparam int unsigned CntW = $clog2(ssab_pkg::OutDepth + 1);

  logic            blend_ok, ram_we;
  logic [31:0]     tex;
  logic [15:0]     a_prod;
  logic [CntW-1:0] pending;

  logic                  b1_v_q, b1_skip_q;
  logic [31:0]           b1_dest_q;
  logic                  b2_v_q, b2_skip_q;
  logic [7:0]            b2_a1_q;
  logic [2:0][7:0]       b2_tc_q, b2_oc_q;
  logic [31:0]           b2_dest_q;
  logic                  b3_v_q, b3_skip_q;
  logic [2:0][15:0]      b3_pt_q, b3_po_q;
  logic [2:0][7:0]       b3_tc_q;
  logic [31:0]           b3_dest_q;

  logic [2:0][7:0]       chan;
  logic [32:0]           res_word;

  logic [32:0]           obuf_q [ssab_pkg::OutDepth];
  logic [PtrW-1:0]       owptr_q, orptr_q;
  logic [CntW-1:0]       ocnt_q;
  logic                  out_pop;

  // A blend is issued only if its result has a guaranteed slot in the buffer.
  assign pending  = CntW'(b1_v_q) + CntW'(b2_v_q) + CntW'(b3_v_q) + ocnt_q;
  assign blend_ok = pending < CntW'(ssab_pkg::OutDepth);
  assign q_pop_o  = q_stat_i.valid && (q_head_i.is_write || blend_ok);
  assign ram_we   = q_pop_o && q_head_i.is_write;

  ssab_ram #(
    .Width (32),
    .Depth (TEX_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (q_head_i.addr[AW-1:0]),
    .wdata_i (q_head_i.data),
    .rdata_o (tex)
  );

  assign a_prod = tex[31:24] * tint_i[31:24];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      b3_v_q <= 1'b0;
    end else begin
      b1_v_q <= q_pop_o && !q_head_i.is_write;
      b2_v_q <= b1_v_q;
      b3_v_q <= b2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_skip_q <= q_head_i.skip;
    b1_dest_q <= q_head_i.data;

    b2_skip_q <= b1_skip_q || (tex[31:24] == 8'd0);
    b2_a1_q   <= a_prod[15:8];
    b2_dest_q <= b1_dest_q;
    for (int c = 0; c < 3; c++) begin
      b2_tc_q[c] <= tex[8*c +: 8];
      b2_oc_q[c] <= b1_dest_q[8*c +: 8];
    end

    b3_skip_q <= b2_skip_q;
    b3_dest_q <= b2_dest_q;
    for (int c = 0; c < 3; c++) begin
      b3_pt_q[c] <= tint_i[8*c +: 8] * b2_a1_q;
      b3_po_q[c] <= (ssab_pkg::ByteMax - b2_a1_q) * b2_oc_q[c];
      b3_tc_q[c] <= b2_tc_q[c];
    end
  end

  always_comb begin
    logic [24:0] sum;
    for (int c = 0; c < 3; c++) begin
      sum     = 25'(b3_pt_q[c] * b3_tc_q[c]) + 25'({b3_po_q[c], 8'h00});
      chan[c] = sum[23:16];
    end
    res_word = b3_skip_q ? {1'b0, b3_dest_q}
                         : {1'b1, ssab_pkg::AlphaOpaque, chan[2], chan[1], chan[0]};
  end

  // Result buffer.
  assign out_pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owptr_q <= '0;
      orptr_q <= '0;
      ocnt_q  <= '0;
    end else begin
      if (b3_v_q)  owptr_q <= owptr_q + 1'b1;
      if (out_pop) orptr_q <= orptr_q + 1'b1;
      ocnt_q <= ocnt_q + CntW'(b3_v_q) - CntW'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (b3_v_q) obuf_q[owptr_q] <= res_word;
  end

  assign out_o.valid     = (ocnt_q != '0);
  assign out_o.written   = obuf_q[orptr_q][32];
  assign out_o.out_color = obuf_q[orptr_q][31:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending <= CntW'(ssab_pkg::OutDepth))
    else $error("result buffer oversubscribed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_head_i.is_write |=> !b1_v_q)
    else $error("texel write started a blend");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && !q_head_i.is_write |-> ##3 b3_v_q)
    else $error("blend lost in the back pipeline");

endmodule

@@ rtl/core/scaled_sprite_alpha_blit.sv @@
// ----------------------------------------------------------------------------
// scaled_sprite_alpha_blit: scaled sprite blitter with tinted alpha blend
// Texel store loaded by write words; blend words map a destination pixel
// to a source texel and return the blended or unchanged colour.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake            Word
//  in_i     in   valid/ready          req_type, tex_addr, tex_data, pixel_x,
//                                     pixel_y, dest_color
//  out_o    out  valid/ready          out_color, written
//  APB      in   psel/penable/pready  8 registers at byte address 4*index
//
// One word is accepted per clock while in_i.ready is high. A blend word passes
// four front-end stages (offset, scale multiply, clip, address multiply), the
// queue, the store's registered read and two blend stages on its way to the
// output buffer. The single store port serves one write or one read per cycle.
// Reset is asynchronous and active low; it clears the pipeline valids, queue
// and buffer pointers and sets the registers to their defaults. The texel
// store has no reset. A stalled output fills the buffer, then the queue, and
// only then deasserts in_i.ready.
// ----------------------------------------------------------------------------
module scaled_sprite_alpha_blit #(
  parameter int unsigned TEX_WORDS  = ssab_pkg::TexWords,
  parameter int unsigned COORD_BITS = ssab_pkg::CoordBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ssab_in_if.sink                       in_i,
  ssab_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssab_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  ssab_pkg::cfg_t          cfg;
  ssab_pkg::queue_entry_t  q_in, q_head;
  ssab_pkg::queue_status_t q_stat;
  logic                    q_push, q_pop;

  // Registers are to change only while the blitter is idle; the block does not
  // enforce this. Both ends read them directly without any shadowing.
  ssab_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The front end computes the texel address; the whole pipeline moves
  // together and holds only when its last stage cannot enter the queue.
  ssab_front #(
    .TEX_WORDS  (TEX_WORDS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg),
    .q_stat_i  (q_stat),
    .q_push_o  (q_push),
    .q_entry_o (q_in)
  );

  // Writes and reads travel through the same queue, so every texel read
  // sees all writes accepted before it.
  ssab_queue #(
    .Depth (ssab_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .stat_o  (q_stat)
  );

  // The back end issues a blend only when a buffer slot is reserved for it,
  // so its pipeline never has to stall.
  ssab_back #(
    .TEX_WORDS (TEX_WORDS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_head_i (q_head),
    .q_stat_i (q_stat),
    .q_pop_o  (q_pop),
    .tint_i   (cfg.tint_argb),
    .out_o    (out_o)
  );

endmodule
